// ===== rtl/tcw_pkg.sv =====
// shared types, codes and constants of the text console writer
`default_nettype none

package tcw_pkg;

   localparam int DEF_COLUMNS = 80;
   localparam int DEF_ROWS    = 25;

   localparam int OPCODE_W    = 2;
   localparam int CHAR_W      = 8;
   localparam int ATTR_W      = 8;
   localparam int ADDR_W      = 11;
   localparam int COL_OUT_W   = 7;
   localparam int ROW_OUT_W   = 5;
   localparam int POS_OUT_W   = 11;
   localparam int CELL_W      = ATTR_W + CHAR_W;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [OPCODE_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
   localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'h20;
   localparam logic [ATTR_W-1:0] FILL_ATTR_RESET = 8'h0F;

   typedef logic [2:0] cmd_kind_type;

   localparam cmd_kind_type CMD_NOP     = 3'd0;
   localparam cmd_kind_type CMD_PUT     = 3'd1;
   localparam cmd_kind_type CMD_NEWLINE = 3'd2;
   localparam cmd_kind_type CMD_READ    = 3'd3;
   localparam cmd_kind_type CMD_CLEAR   = 3'd4;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [CHAR_W-1:0] char_code;
      logic [ATTR_W-1:0] attribute;
      logic [ADDR_W-1:0] cell_index;
   } cmd_type;

endpackage

`default_nettype wire

// ===== rtl/text_console_writer_unit.sv =====
// top level of the text console writer
//
// Requests arrive on the req_ channel (valid/stall), results leave on the
// rsp_ channel (valid/stall), and the fill attribute is written on the csr_
// channel (valid/ready; ready is always high). Every transaction on req_
// gives exactly one transaction on rsp_, in order.
// A front part classifies requests into a two-entry command queue; a back
// part owns the screen store (one write and one registered read port) and
// the cursor and executes commands one at a time.
// A request passes through the command queue and the result register, and
// an in-range cell read also through the store's registered read port.
// Throughput is one transaction per cycle while rsp_stall is low and no
// read, scroll or clear is in progress. A put or newline that runs past the
// last row scrolls, the single store write port moving one cell per cycle;
// a clear sweeps every cell to blank and returns when the sweep ends.
// After reset every one of the COLUMNS*ROWS cells (2000 at the default size)
// is swept to zero; requests are queued meanwhile, then stalled.
// While rsp_stall is high the result holds and the queue keeps taking up to
// two requests before req_stall rises.
`default_nettype none

module text_console_writer_unit #(
   parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
   parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [tcw_pkg::OPCODE_W-1:0]  req_opcode,
   input  wire logic [tcw_pkg::CHAR_W-1:0]    req_char_code,
   input  wire logic [tcw_pkg::ATTR_W-1:0]    req_attribute,
   input  wire logic [tcw_pkg::ADDR_W-1:0]    req_cell_address,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [tcw_pkg::COL_OUT_W-1:0]      rsp_cursor_column,
   output logic [tcw_pkg::ROW_OUT_W-1:0]      rsp_cursor_row,
   output logic [tcw_pkg::POS_OUT_W-1:0]      rsp_cursor_position,
   output logic [tcw_pkg::CELL_W-1:0]         rsp_cell_data,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [tcw_pkg::ATTR_W-1:0]    csr_fill_attribute
);
   import tcw_pkg::*;

   logic    push_valid;
   logic    push_stall;
   cmd_type push_data;
   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd_data;

   tcw_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_char_code    (req_char_code),
      .req_attribute    (req_attribute),
      .req_cell_address (req_cell_address),
      .push_valid       (push_valid),
      .push_stall       (push_stall),
      .push_data        (push_data)
   );

   tcw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_stall (push_stall),
      .push_data  (push_data),
      .pop_valid  (cmd_valid),
      .pop_ready  (cmd_pop),
      .pop_data   (cmd_data)
   );

   tcw_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .cmd_valid           (cmd_valid),
      .cmd_pop             (cmd_pop),
      .cmd_data            (cmd_data),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_cursor_column   (rsp_cursor_column),
      .rsp_cursor_row      (rsp_cursor_row),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_cell_data       (rsp_cell_data),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_fill_attribute  (csr_fill_attribute)
   );

endmodule

`default_nettype wire

// ===== rtl/tcw_queue.sv =====
// short command queue between the front and back parts
`default_nettype none

module tcw_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_stall,
   input  wire tcw_pkg::cmd_type push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output tcw_pkg::cmd_type      pop_data
);
   import tcw_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push, pop;

   assign push_stall = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && !push_stall;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/tcw_front.sv =====
// request intake and command classification
`default_nettype none

module tcw_front #(
   parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
   parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [tcw_pkg::OPCODE_W-1:0]  req_opcode,
   input  wire logic [tcw_pkg::CHAR_W-1:0]    req_char_code,
   input  wire logic [tcw_pkg::ATTR_W-1:0]    req_attribute,
   input  wire logic [tcw_pkg::ADDR_W-1:0]    req_cell_address,
   output logic                               push_valid,
   input  wire logic                          push_stall,
   output tcw_pkg::cmd_type                   push_data
);
   import tcw_pkg::*;

   localparam int CELLS     = COLUMNS * ROWS;
   localparam int INDEX_W   = $clog2(CELLS);
   localparam int CMP_W     = ((INDEX_W > ADDR_W) ? INDEX_W : ADDR_W) + 1;

   logic in_range;

   assign in_range   = (CMP_W'(req_cell_address) < CMP_W'(CELLS));
   assign req_stall  = push_stall;
   assign push_valid = req_valid;

   always_comb begin
      push_data.char_code  = req_char_code;
      push_data.attribute  = req_attribute;
      push_data.cell_index = req_cell_address;
      unique case (req_opcode)
         OP_PUT: begin
            push_data.kind = (req_char_code == NEWLINE_CODE) ? CMD_NEWLINE : CMD_PUT;
         end
         OP_READ: begin
            push_data.kind = in_range ? CMD_READ : CMD_NOP;
         end
         OP_CLEAR: begin
            push_data.kind = CMD_CLEAR;
         end
         default: begin
            push_data.kind = CMD_NOP;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/tcw_back.sv =====
// command execution: screen store, cursor, scroll and clear sweeps, result register
`default_nettype none

module tcw_back #(
   parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
   parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           cmd_valid,
   output logic                                cmd_pop,
   input  wire tcw_pkg::cmd_type               cmd_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [tcw_pkg::COL_OUT_W-1:0]       rsp_cursor_column,
   output logic [tcw_pkg::ROW_OUT_W-1:0]       rsp_cursor_row,
   output logic [tcw_pkg::POS_OUT_W-1:0]       rsp_cursor_position,
   output logic [tcw_pkg::CELL_W-1:0]          rsp_cell_data,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [tcw_pkg::ATTR_W-1:0]     csr_fill_attribute
);
   import tcw_pkg::*;

   localparam int CELLS   = COLUMNS * ROWS;
   localparam int INDEX_W = $clog2(CELLS);
   localparam int COL_W   = $clog2(COLUMNS);
   localparam int ROW_W   = $clog2(ROWS);

   localparam logic [COL_W-1:0]   LAST_COL   = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0]   LAST_ROW   = ROW_W'(ROWS - 1);
   localparam logic [INDEX_W-1:0] LAST_CELL  = INDEX_W'(CELLS - 1);
   localparam logic [INDEX_W-1:0] COPY_END   = INDEX_W'(CELLS - COLUMNS);
   localparam logic [INDEX_W-1:0] LAST_POS   = INDEX_W'((ROWS - 1) * COLUMNS);
   localparam logic [INDEX_W-1:0] ROW_STRIDE = INDEX_W'(COLUMNS);

   localparam logic [2:0] ST_INIT  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_COPY  = 3'd3;
   localparam logic [2:0] ST_FILL  = 3'd4;
   localparam logic [2:0] ST_CLEAR = 3'd5;

   logic [CELL_W-1:0]    screen_mem [CELLS];
   logic [CELL_W-1:0]    rd_data_ff;

   logic [2:0]           state_ff, state_in;
   logic [INDEX_W-1:0]   cnt_ff, cnt_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [INDEX_W-1:0]   pos_ff, pos_in;
   logic [ATTR_W-1:0]    fill_attr_ff, fill_attr_in;
   logic                 pend_ff, pend_in;
   logic [INDEX_W-1:0]   dst_ff, dst_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COL_OUT_W-1:0] rsp_col_ff, rsp_col_in;
   logic [ROW_OUT_W-1:0] rsp_row_ff, rsp_row_in;
   logic [POS_OUT_W-1:0] rsp_pos_ff, rsp_pos_in;
   logic [CELL_W-1:0]    rsp_data_ff, rsp_data_in;

   logic                 mem_we;
   logic [INDEX_W-1:0]   mem_waddr;
   logic [CELL_W-1:0]    mem_wdata;
   logic [INDEX_W-1:0]   mem_raddr;

   logic                 out_free;
   logic                 load;
   logic [CELL_W-1:0]    load_data;
   logic [CELL_W-1:0]    blank;
   logic                 start_scroll;

   assign csr_ready    = 1'b1;
   assign fill_attr_in = (csr_valid && csr_ready) ? csr_fill_attribute : fill_attr_ff;
   assign blank        = {fill_attr_ff, BLANK_CODE};
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign cmd_pop      = (state_ff == ST_IDLE) && cmd_valid && out_free;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cursor_column   = rsp_col_ff;
   assign rsp_cursor_row      = rsp_row_ff;
   assign rsp_cursor_position = rsp_pos_ff;
   assign rsp_cell_data       = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      pos_in       = pos_ff;
      pend_in      = 1'b0;
      dst_in       = cnt_ff;
      mem_we       = 1'b0;
      mem_waddr    = cnt_ff;
      mem_wdata    = '0;
      mem_raddr    = cnt_ff;
      load         = 1'b0;
      load_data    = '0;
      start_scroll = 1'b0;

      unique case (state_ff)
         ST_INIT: begin
            mem_we = 1'b1;
            if (cnt_ff == LAST_CELL) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            mem_raddr = INDEX_W'(cmd_data.cell_index);
            if (cmd_pop) begin
               case (cmd_data.kind)
                  CMD_PUT: begin
                     mem_we    = 1'b1;
                     mem_waddr = pos_ff;
                     mem_wdata = {cmd_data.attribute, cmd_data.char_code};
                     if (col_ff == LAST_COL) begin
                        if (row_ff == LAST_ROW) begin
                           start_scroll = 1'b1;
                        end else begin
                           col_in = '0;
                           row_in = row_ff + 1'b1;
                           pos_in = pos_ff + 1'b1;
                           load   = 1'b1;
                        end
                     end else begin
                        col_in = col_ff + 1'b1;
                        pos_in = pos_ff + 1'b1;
                        load   = 1'b1;
                     end
                  end
                  CMD_NEWLINE: begin
                     if (row_ff == LAST_ROW) begin
                        start_scroll = 1'b1;
                     end else begin
                        col_in = '0;
                        row_in = row_ff + 1'b1;
                        pos_in = pos_ff - INDEX_W'(col_ff) + ROW_STRIDE;
                        load   = 1'b1;
                     end
                  end
                  CMD_READ: begin
                     state_in = ST_READ;
                  end
                  CMD_CLEAR: begin
                     cnt_in   = '0;
                     col_in   = '0;
                     row_in   = '0;
                     pos_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  default: begin
                     load = 1'b1;
                  end
               endcase
               if (start_scroll) begin
                  col_in   = '0;
                  row_in   = LAST_ROW;
                  pos_in   = LAST_POS;
                  cnt_in   = '0;
                  state_in = ST_COPY;
               end
            end
         end
         ST_READ: begin
            load      = 1'b1;
            load_data = rd_data_ff;
            state_in  = ST_IDLE;
         end
         ST_COPY: begin
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = dst_ff;
               mem_wdata = rd_data_ff;
            end
            if (cnt_ff == COPY_END) begin
               state_in = ST_FILL;
            end else begin
               mem_raddr = cnt_ff + ROW_STRIDE;
               pend_in   = 1'b1;
               dst_in    = cnt_ff;
               cnt_in    = cnt_ff + 1'b1;
            end
         end
         ST_FILL, ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = blank;
            if (cnt_ff == LAST_CELL) begin
               cnt_in   = '0;
               load     = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && rsp_stall);
      rsp_col_in   = load ? COL_OUT_W'(col_in) : rsp_col_ff;
      rsp_row_in   = load ? ROW_OUT_W'(row_in) : rsp_row_ff;
      rsp_pos_in   = load ? POS_OUT_W'(pos_in) : rsp_pos_ff;
      rsp_data_in  = load ? load_data : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         pos_ff       <= '0;
         fill_attr_ff <= FILL_ATTR_RESET;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         pos_ff       <= pos_in;
         fill_attr_ff <= fill_attr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dst_ff      <= dst_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= screen_mem[mem_raddr];
   end

`ifndef SYNTHESIS
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      row_ff <= LAST_ROW)
      else $error("cursor row beyond last row");

   a_pos_match: assert property (@(posedge clock) disable iff (reset)
      32'(pos_ff) == 32'(row_ff) * 32'(COLUMNS) + 32'(col_ff))
      else $error("linear cursor position out of step with row and column");

   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !rsp_valid_ff)
      else $error("result pending while a sweep or read is in progress");

   a_scroll_cursor: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COPY || state_ff == ST_FILL |-> col_ff == '0 && row_ff == LAST_ROW)
      else $error("cursor not parked on last row during scroll");
`endif

endmodule

`default_nettype wire
